>>> rtl/dct3d_pkg.sv
package dct3d_pkg;

  localparam int SW        = 16;   // sample and result width
  localparam int DW        = 24;   // working value width, holds any pass result
  localparam int CW        = 15;   // cosine coefficient width
  localparam int PW        = DW + CW;
  localparam int AW        = 42;   // accumulator width
  localparam int QBITS     = 14;
  localparam int QROUND    = 8192;
  localparam int DRAIN_CYC = 16;   // wait after a pass's last read, outlasting its last write

  typedef struct packed {
    logic       valid;
    logic [5:0] line;
    logic [2:0] idx;
  } tag_t;

  typedef struct packed {
    logic                 done;
    logic [5:0]           line;
    logic signed [AW-1:0] acc;
  } cres_t;

  // Q14 cosine basis, row r (frequency) and column c (position)
  function automatic logic signed [CW-1:0] cos_q(input logic [2:0] r, input logic [2:0] c);
    logic [6:0]  m;
    logic [4:0]  q;
    logic [3:0]  j;
    logic        neg;
    logic [13:0] mag;
    m   = {3'b000, c, 1'b1} * {4'b0000, r};
    q   = m[4:0];
    j   = 4'd0;
    neg = 1'b0;
    if (q <= 5'd8) begin
      j = q[3:0];
    end else if (q <= 5'd16) begin
      j   = 4'(5'd16 - q);
      neg = 1'b1;
    end else if (q <= 5'd24) begin
      j   = 4'(q - 5'd16);
      neg = 1'b1;
    end else begin
      j = 4'(6'd32 - {1'b0, q});
    end
    if (r == 3'd0) begin
      j   = 4'd4;
      neg = 1'b0;
    end
    case (j)
      4'd0:    mag = 14'd8192;
      4'd1:    mag = 14'd8035;
      4'd2:    mag = 14'd7568;
      4'd3:    mag = 14'd6811;
      4'd4:    mag = 14'd5793;
      4'd5:    mag = 14'd4551;
      4'd6:    mag = 14'd3135;
      4'd7:    mag = 14'd1598;
      default: mag = 14'd0;
    endcase
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

>>> rtl/dct3d_ram.sv
module dct3d_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dct3d_cell.sv
module dct3d_cell #(
  parameter logic [2:0] K = 3'd0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              inv,
  input  logic signed [dct3d_pkg::DW-1:0]   x_in,
  input  dct3d_pkg::tag_t                   tag_in,
  output logic signed [dct3d_pkg::DW-1:0]   x_out,
  output dct3d_pkg::tag_t                   tag_out,
  output dct3d_pkg::cres_t                  res
);

  logic signed [dct3d_pkg::CW-1:0] coef;
  logic signed [dct3d_pkg::PW-1:0] prod_nxt;
  logic signed [dct3d_pkg::AW-1:0] prod_ext;

  logic signed [dct3d_pkg::DW-1:0] x_r;
  dct3d_pkg::tag_t                 tag_r;
  logic signed [dct3d_pkg::PW-1:0] prod_r;
  dct3d_pkg::tag_t                 ptag_r;
  logic signed [dct3d_pkg::AW-1:0] acc_r;
  dct3d_pkg::tag_t                 atag_r;

  // inverse uses the transposed basis
  assign coef     = inv ? dct3d_pkg::cos_q(tag_in.idx, K) : dct3d_pkg::cos_q(K, tag_in.idx);
  assign prod_nxt = x_in * coef;
  assign prod_ext = dct3d_pkg::AW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid  <= 1'b0;
      ptag_r.valid <= 1'b0;
      atag_r.valid <= 1'b0;
    end else begin
      x_r    <= x_in;
      tag_r  <= tag_in;
      prod_r <= prod_nxt;
      ptag_r <= tag_in;
      atag_r <= ptag_r;
      if (ptag_r.valid) begin
        acc_r <= (ptag_r.idx == 3'd0) ? prod_ext : acc_r + prod_ext;
      end
    end
  end

  assign x_out    = x_r;
  assign tag_out  = tag_r;
  assign res.done = atag_r.valid && (atag_r.idx == 3'd7);
  assign res.line = atag_r.line;
  assign res.acc  = acc_r;

endmodule

>>> rtl/int_dct3d_8x8x8_core.sv
// 3-D integer DCT-II (or its inverse) on one 8x8x8 sub-block. Load 64 rows of eight samples
// (z-major, then y, x across the row); after the 64th row the block runs three separable
// 8-point passes and then returns 64 result rows in the same order, last_row marking the
// final one. Mode and dc bias are taken when the 64th row is accepted. A chain of eight MAC
// cells fed one element per cycle from the single-read-port sample and work memories sets
// the pace: each pass reads all 512 elements and then drains the chain, and each result row
// is read from the sample store and then loaded into the output register. Input is not
// taken while a block is transformed or emitted; the last result row may still wait while
// the next block loads.
module int_dct3d_8x8x8_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample_0,
  input  logic signed [15:0] in_sample_1,
  input  logic signed [15:0] in_sample_2,
  input  logic signed [15:0] in_sample_3,
  input  logic signed [15:0] in_sample_4,
  input  logic signed [15:0] in_sample_5,
  input  logic signed [15:0] in_sample_6,
  input  logic signed [15:0] in_sample_7,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value_0,
  output logic signed [15:0] out_value_1,
  output logic signed [15:0] out_value_2,
  output logic signed [15:0] out_value_3,
  output logic signed [15:0] out_value_4,
  output logic signed [15:0] out_value_5,
  output logic signed [15:0] out_value_6,
  output logic signed [15:0] out_value_7,
  output logic               out_last_row,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DW = dct3d_pkg::DW;
  localparam int AW = dct3d_pkg::AW;
  localparam int SW = dct3d_pkg::SW;

  localparam logic REG_INV = 1'b0;
  localparam logic REG_DC  = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] PASS_FIRST = 2'd0;
  localparam logic [1:0] PASS_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  function automatic logic [8:0] elem_addr(input logic [1:0] axis, input logic [5:0] line,
                                           input logic [2:0] i);
    logic [8:0] a;
    unique case (axis)
      AX_X:    a = {line, i};
      AX_Y:    a = {line[5:3], i, line[2:0]};
      AX_Z:    a = {i, line};
      default: a = {line, i};
    endcase
    return a;
  endfunction

  state_t      state_r;
  logic [5:0]  row_cnt_r;
  logic [1:0]  pass_r;
  logic [8:0]  cnt_r;
  logic [4:0]  drain_r;
  logic [5:0]  emit_r;
  logic        inv_cfg_r;
  logic [7:0]  dc_cfg_r;
  logic        inv_r;
  logic [7:0]  dc_r;
  logic        out_valid_r;
  logic        out_last_r;
  logic [SW-1:0] out_v_r [8];

  logic signed [SW-1:0] in_s [8];
  logic        in_acc;
  logic        cfg_wr;
  logic [1:0]  axis;

  assign in_s[0] = in_sample_0;
  assign in_s[1] = in_sample_1;
  assign in_s[2] = in_sample_2;
  assign in_s[3] = in_sample_3;
  assign in_s[4] = in_sample_4;
  assign in_s[5] = in_sample_5;
  assign in_s[6] = in_sample_6;
  assign in_s[7] = in_sample_7;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign axis     = inv_r ? 2'(PASS_LAST - pass_r) : pass_r;

  always_comb begin
    unique case (paddr[2])
      REG_DC:  prdata = {24'd0, dc_cfg_r};
      REG_INV: prdata = {31'd0, inv_cfg_r};
    endcase
  end

  // read side: one element per cycle
  logic [8:0]      rd_addr;
  logic [5:0]      s_raddr;
  logic [SW-1:0]   s_q [8];
  logic [DW-1:0]   a_q [8];
  dct3d_pkg::tag_t rd_tag_r;
  logic [2:0]      rd_lane_r;
  logic signed [DW-1:0] f_r;
  dct3d_pkg::tag_t      f_tag_r;
  logic signed [DW-1:0] elem;
  logic signed [DW-1:0] dc_x;

  assign rd_addr = elem_addr(axis, cnt_r[8:3], cnt_r[2:0]);
  assign s_raddr = (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD) ? emit_r : rd_addr[8:3];
  assign dc_x    = {{(DW-8){1'b0}}, dc_r};

  always_comb begin
    if (pass_r == PASS_FIRST) begin
      elem = DW'($signed(s_q[rd_lane_r])) - (inv_r ? DW'(0) : dc_x);
    end else begin
      elem = $signed(a_q[rd_lane_r]);
    end
  end

  // cell chain
  logic signed [DW-1:0] x_c [8];
  dct3d_pkg::tag_t      t_c [8];
  dct3d_pkg::cres_t     res [8];
  logic [7:0]           done_v;

  for (genvar k = 0; k < 8; k++) begin : g_cell
    if (k == 0) begin : g_head
      dct3d_cell #(.K(3'(k))) u_cell (
        .clk(clk), .rst_n(rst_n), .inv(inv_r),
        .x_in(f_r), .tag_in(f_tag_r),
        .x_out(x_c[k]), .tag_out(t_c[k]), .res(res[k])
      );
    end else begin : g_body
      dct3d_cell #(.K(3'(k))) u_cell (
        .clk(clk), .rst_n(rst_n), .inv(inv_r),
        .x_in(x_c[k-1]), .tag_in(t_c[k-1]),
        .x_out(x_c[k]), .tag_out(t_c[k]), .res(res[k])
      );
    end
    assign done_v[k] = res[k].done;
  end

  // write-back: cells finish one after another, at most one per cycle
  logic signed [AW-1:0] sel_acc;
  logic [5:0]           sel_line;
  logic [2:0]           sel_k;
  logic                 sel_any;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] biased;
  logic [SW-1:0]        fin;
  logic [8:0]           wb_addr;

  always_comb begin
    sel_acc  = res[0].acc;
    sel_line = res[0].line;
    sel_k    = 3'd0;
    sel_any  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (res[k].done) begin
        sel_acc  = res[k].acc;
        sel_line = res[k].line;
        sel_k    = 3'(k);
        sel_any  = 1'b1;
      end
    end
  end

  assign rnd     = (sel_acc + AW'(dct3d_pkg::QROUND)) >>> dct3d_pkg::QBITS;
  assign biased  = rnd + $signed({{(AW-8){1'b0}}, dc_r});
  assign wb_addr = elem_addr(axis, sel_line, sel_k);

  always_comb begin
    if (!inv_r) begin
      if (rnd > AW'(32767))       fin = 16'h7FFF;
      else if (rnd < AW'(-32768)) fin = 16'h8000;
      else                        fin = rnd[SW-1:0];
    end else begin
      if (biased < AW'(0))        fin = 16'h0000;
      else if (biased > AW'(255)) fin = 16'h00FF;
      else                        fin = biased[SW-1:0];
    end
  end

  logic          wb_valid_r;
  logic [8:0]    wb_addr_r;
  logic [DW-1:0] wb_data_r;
  logic [SW-1:0] wb_fin_r;

  // memories: sample store doubles as result store, work store is updated in place
  for (genvar k = 0; k < 8; k++) begin : g_lane
    logic          s_we;
    logic [SW-1:0] s_wd;
    logic          a_we;

    assign s_we = in_acc ||
                  (wb_valid_r && pass_r == PASS_LAST && wb_addr_r[2:0] == 3'(k));
    assign s_wd = in_acc ? in_s[k] : wb_fin_r;
    assign a_we = wb_valid_r && pass_r != PASS_LAST && wb_addr_r[2:0] == 3'(k);

    dct3d_ram #(.W(SW), .D(64)) u_s_ram (
      .clk(clk), .we(s_we), .waddr(in_acc ? row_cnt_r : wb_addr_r[8:3]), .wdata(s_wd),
      .raddr(s_raddr), .rdata(s_q[k])
    );

    dct3d_ram #(.W(DW), .D(64)) u_a_ram (
      .clk(clk), .we(a_we), .waddr(wb_addr_r[8:3]), .wdata(wb_data_r),
      .raddr(rd_addr[8:3]), .rdata(a_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r.valid <= 1'b0;
      f_tag_r.valid  <= 1'b0;
      wb_valid_r     <= 1'b0;
    end else begin
      rd_tag_r.valid <= (state_r == ST_RUN);
      rd_tag_r.line  <= cnt_r[8:3];
      rd_tag_r.idx   <= cnt_r[2:0];
      rd_lane_r      <= rd_addr[2:0];
      f_r            <= elem;
      f_tag_r        <= rd_tag_r;
      wb_valid_r     <= sel_any;
      wb_addr_r      <= wb_addr;
      wb_data_r      <= rnd[DW-1:0];
      wb_fin_r       <= fin;
    end
  end

  // control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      row_cnt_r   <= '0;
      pass_r      <= PASS_FIRST;
      cnt_r       <= '0;
      drain_r     <= '0;
      emit_r      <= '0;
      inv_cfg_r   <= 1'b0;
      dc_cfg_r    <= '0;
      inv_r       <= 1'b0;
      dc_r        <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_DC:  dc_cfg_r  <= pwdata[7:0];
          REG_INV: inv_cfg_r <= pwdata[0];
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            row_cnt_r <= row_cnt_r + 6'd1;
            if (row_cnt_r == 6'd63) begin
              inv_r   <= inv_cfg_r;
              dc_r    <= dc_cfg_r;
              pass_r  <= PASS_FIRST;
              cnt_r   <= '0;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 9'd1;
          if (cnt_r == 9'd511) begin
            drain_r <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 5'd1;
          if (drain_r == 5'(dct3d_pkg::DRAIN_CYC - 1)) begin
            if (pass_r == PASS_LAST) begin
              emit_r  <= '0;
              state_r <= ST_EMIT_RD;
            end else begin
              pass_r  <= pass_r + 2'd1;
              cnt_r   <= '0;
              state_r <= ST_RUN;
            end
          end
        end
        ST_EMIT_RD: begin
          // row is read now, shown once the output register is free
          if (!out_valid_r || out_ready) begin
            state_r <= ST_EMIT_LD;
          end
        end
        ST_EMIT_LD: begin
          out_valid_r <= 1'b1;
          out_last_r  <= (emit_r == 6'd63);
          for (int k = 0; k < 8; k++) begin
            out_v_r[k] <= s_q[k];
          end
          emit_r  <= emit_r + 6'd1;
          state_r <= (emit_r == 6'd63) ? ST_LOAD : ST_EMIT_RD;
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_last_row = out_last_r;
  assign out_value_0  = out_v_r[0];
  assign out_value_1  = out_v_r[1];
  assign out_value_2  = out_v_r[2];
  assign out_value_3  = out_v_r[3];
  assign out_value_4  = out_v_r[4];
  assign out_value_5  = out_v_r[5];
  assign out_value_6  = out_v_r[6];
  assign out_value_7  = out_v_r[7];

  a_one_done: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(done_v))
    else $error("two cells finished in one cycle");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && drain_r == 5'(dct3d_pkg::DRAIN_CYC - 1))
      |-> (!wb_valid_r && done_v == 8'd0 && !f_tag_r.valid && !rd_tag_r.valid))
    else $error("pass ended with work still in the chain");

  a_wb_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("write-back outside a pass");

  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD) |-> !out_valid_r)
    else $error("result row overwritten before taken");

  a_pass_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_r != $past(pass_r) && $past(rst_n)) |-> ($past(state_r) == ST_DRAIN ||
                                                    $past(state_r) == ST_LOAD))
    else $error("pass changed mid-pass");

endmodule
